### design/pctg_pkg.sv
// Package for the potentiometer-controlled tone generator.
// Holds the shared widths, constants, state and command types.
// Depends on nothing; every design file but pctg_ram imports it.
package pctg_pkg;

  localparam int WINDOW_DEF = 250;

  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 12;
  localparam int PITCH_W  = 15;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Shared divider: 30-bit dividend, 16-bit divisor, two quotient bits a cycle.
  localparam int DIVN_W  = 30;
  localparam int DIVS_W  = 16;
  localparam int STEPS   = DIVN_W / 2;
  localparam int DCNT_W  = $clog2(STEPS + 1);

  localparam logic [SAMPLE_W-1:0] PIVOT     = 16'd53000;
  localparam logic [SAMPLE_W-1:0] AVG_TOP   = 16'd65535;
  localparam logic [9:0]          LO_MUL    = 10'd980;
  localparam logic [14:0]         HI_MUL    = 15'd24000;
  localparam logic [DIVS_W-1:0]   LO_DIV    = 16'd53000;
  localparam logic [DIVS_W-1:0]   HI_DIV    = 16'd12534;
  localparam logic [PITCH_W-1:0]  LO_BASE   = 15'd20;
  localparam logic [PITCH_W-1:0]  HI_BASE   = 15'd1000;
  localparam logic [DIVN_W-1:0]   PER_NUM   = 30'd50000;
  localparam logic [PITCH_W-1:0]  PITCH_RST = 15'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'd2500;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG_GO,
    S_AVG_WAIT,
    S_MUL,
    S_PIT_GO,
    S_PIT_WAIT,
    S_PER_GO,
    S_PER_WAIT,
    S_TICK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_AVG,
    DIV_PIT,
    DIV_PER
  } div_op_t;

  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_LOW,
    SEL_HIGH
  } pitch_sel_t;

  typedef struct packed {
    logic    capture;
    logic    sum_upd;
    logic    div_start;
    div_op_t div_op;
    logic    avg_ld;
    logic    mul_ld;
    logic    pitch_ld;
    logic    period_ld;
    logic    tick_upd;
    logic    out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       out_free;
    pitch_sel_t pitch_sel;
  } dp_stat_t;

endpackage

### design/pot_controlled_tone_generator_core.sv
// Potentiometer-controlled tone generator: boxcar average of samples, piecewise
// pitch map, half-period from pitch, square wave advanced by timer ticks.
// A tick goes through the tick update to the done state, which loads the output
// register once it is free; a sample takes two passes of the shared 2-bit-per-cycle
// divider (three when the pitch is recomputed). No new item is taken before the load.
// Synchronous active-low reset clears the window by a fill flag, no clearing pass.
module pot_controlled_tone_generator_core #(
  parameter int WINDOW = pctg_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pctg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                             in_tuser,   // [0] cmd: 0 sample, 1 tick
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pctg_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] tone_level,
                                                       // [12:1] half_period,
                                                       // [28:13] filtered_level
);
  import pctg_pkg::*;

  ctrl_cmd_t cmd_s;
  dp_stat_t  stat_s;

  pctg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_kind  (in_tuser),
    .in_tready(in_tready),
    .stat     (stat_s),
    .cmd      (cmd_s)
  );

  pctg_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_s),
    .stat      (stat_s),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata)
  );

  // A tick transfer goes straight to the counter update.
  a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> cmd_s.tick_upd)
    else $error("tick transfer did not reach the counter update");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.div_start |=> stat_s.div_busy)
    else $error("divider did not start");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.out_ld |=> out_tvalid)
    else $error("result load did not raise out_tvalid");

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_s.sum_upd, cmd_s.avg_ld, cmd_s.pitch_ld, cmd_s.period_ld,
              cmd_s.tick_upd, cmd_s.out_ld}))
    else $error("more than one datapath update in a cycle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat_s.div_busy |-> !in_tready)
    else $error("input ready while the divider is busy");

endmodule

### design/pctg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; the contents have no reset.
module pctg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pctg_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on pctg_pkg for its widths.
module pctg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pctg_pkg::DIVN_W-1:0] dividend,
  input  logic [pctg_pkg::DIVS_W-1:0] divisor,
  output logic                       busy,
  output logic [pctg_pkg::DIVN_W-1:0] quotient
);
  import pctg_pkg::*;

  logic              busy_r, busy_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dsr_r, dsr_nxt;

  logic [DIVS_W:0]   sh1, sh2, t1, t2;
  logic [DIVS_W-1:0] r1;
  logic              b1, b2;

  always_comb begin
    sh1 = {rem_r, quo_r[DIVN_W-1]};
    t1  = sh1 - {1'b0, dsr_r};
    b1  = ~t1[DIVS_W];
    r1  = b1 ? t1[DIVS_W-1:0] : sh1[DIVS_W-1:0];
    sh2 = {r1, quo_r[DIVN_W-2]};
    t2  = sh2 - {1'b0, dsr_r};
    b2  = ~t2[DIVS_W];

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(STEPS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVN_W-3:0], b1, b2};
      rem_nxt = b2 ? t2[DIVS_W-1:0] : sh2[DIVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### design/pctg_dp.sv
// Datapath: sample window in RAM with running sum, averaging and pitch math on
// a shared divider, tick counter, and the output register.
// Depends on pctg_pkg, pctg_ram and pctg_div.
module pctg_dp #(
  parameter int WINDOW = pctg_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pctg_pkg::ctrl_cmd_t             cmd,
  output pctg_pkg::dp_stat_t              stat,
  input  logic [pctg_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [pctg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pctg_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  logic [SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]    widx_r, widx_nxt;
  logic                full_r, full_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [PITCH_W-1:0]  pitch_r, pitch_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] tick_r, tick_nxt;
  logic                tone_r, tone_nxt;
  logic [DIVN_W-1:0]   prod_r;
  pitch_sel_t          sel_r;
  logic                ovalid_r, ovalid_nxt;
  logic [OUT_TDATA_W-1:0] odata_r;

  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] old_val;
  pitch_sel_t          sel_now;
  logic [13:0]         hi_off;
  logic [DIVN_W-1:0]   prod_now;
  logic [DIVN_W-1:0]   div_n;
  logic [DIVS_W-1:0]   div_d;
  logic                div_busy;
  logic [DIVN_W-1:0]   div_q;
  logic [PERIOD_W-1:0] tick_inc;

  pctg_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.sum_upd),
    .waddr(widx_r),
    .wdata(sample_r),
    .raddr(widx_r),
    .rdata(rd_data)
  );

  pctg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_n),
    .divisor (div_d),
    .busy    (div_busy),
    .quotient(div_q)
  );

  // Entries are written in index order, so before the first wrap the entry
  // under the write pointer has never been written and counts as zero.
  assign old_val = full_r ? rd_data : '0;

  always_comb begin
    if (avg_r != '0 && avg_r < PIVOT) begin
      sel_now = SEL_LOW;
    end else if (avg_r > PIVOT && avg_r != AVG_TOP) begin
      sel_now = SEL_HIGH;
    end else begin
      sel_now = SEL_KEEP;
    end
    hi_off = 14'(avg_r - PIVOT);
    if (sel_now == SEL_LOW) begin
      prod_now = DIVN_W'(avg_r) * DIVN_W'(LO_MUL);
    end else begin
      prod_now = DIVN_W'(hi_off) * DIVN_W'(HI_MUL);
    end
  end

  always_comb begin
    case (cmd.div_op)
      DIV_AVG: begin
        div_n = DIVN_W'(sum_r);
        div_d = DIVS_W'(WINDOW);
      end
      DIV_PIT: begin
        div_n = prod_r;
        div_d = (sel_r == SEL_LOW) ? LO_DIV : HI_DIV;
      end
      DIV_PER: begin
        div_n = PER_NUM;
        div_d = DIVS_W'(pitch_r);
      end
      default: begin
        div_n = PER_NUM;
        div_d = DIVS_W'(pitch_r);
      end
    endcase
  end

  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    widx_nxt   = widx_r;
    full_nxt   = full_r;
    sum_nxt    = sum_r;
    avg_nxt    = avg_r;
    pitch_nxt  = pitch_r;
    period_nxt = period_r;
    tick_nxt   = tick_r;
    tone_nxt   = tone_r;
    ovalid_nxt = ovalid_r;

    if (cmd.sum_upd) begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
      if (widx_r == IDX_W'(WINDOW - 1)) begin
        widx_nxt = '0;
        full_nxt = 1'b1;
      end else begin
        widx_nxt = widx_r + 1'b1;
      end
    end
    if (cmd.avg_ld) begin
      avg_nxt = div_q[SAMPLE_W-1:0];
    end
    if (cmd.pitch_ld) begin
      pitch_nxt = ((sel_r == SEL_LOW) ? LO_BASE : HI_BASE) + div_q[PITCH_W-1:0];
    end
    if (cmd.period_ld) begin
      period_nxt = div_q[PERIOD_W-1:0];
    end
    if (cmd.tick_upd) begin
      if (tick_inc >= period_r) begin
        tick_nxt = '0;
        tone_nxt = ~tone_r;
      end else begin
        tick_nxt = tick_inc;
      end
    end
    if (cmd.out_ld) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r   <= '0;
      full_r   <= 1'b0;
      sum_r    <= '0;
      avg_r    <= '0;
      pitch_r  <= PITCH_RST;
      period_r <= PERIOD_RST;
      tick_r   <= '0;
      tone_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      widx_r   <= widx_nxt;
      full_r   <= full_nxt;
      sum_r    <= sum_nxt;
      avg_r    <= avg_nxt;
      pitch_r  <= pitch_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      tone_r   <= tone_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.mul_ld) begin
      prod_r <= prod_now;
      sel_r  <= sel_now;
    end
    if (cmd.out_ld) begin
      odata_r <= {3'b000, avg_r, period_r, tone_r};
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.out_free  = ~ovalid_r | out_tready;
  assign stat.pitch_sel = sel_now;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

### design/pctg_ctrl.sv
// Controller state machine: sequences one item at a time through the datapath.
// Depends on pctg_pkg for the state, command and status types.
module pctg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_kind,
  output logic               in_tready,
  input  pctg_pkg::dp_stat_t stat,
  output pctg_pkg::ctrl_cmd_t cmd
);
  import pctg_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_kind ? S_TICK : S_SUM;
        end
      end
      S_SUM:    state_nxt = S_AVG_GO;
      S_AVG_GO: state_nxt = S_AVG_WAIT;
      S_AVG_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = (stat.pitch_sel == SEL_KEEP) ? S_PER_GO : S_PIT_GO;
      end
      S_PIT_GO: state_nxt = S_PIT_WAIT;
      S_PIT_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_PER_GO;
        end
      end
      S_PER_GO: state_nxt = S_PER_WAIT;
      S_PER_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_TICK: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.div_op = DIV_AVG;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = 1'b1;
      end
      S_SUM: cmd.sum_upd = 1'b1;
      S_AVG_GO: begin
        cmd.div_op    = DIV_AVG;
        cmd.div_start = 1'b1;
      end
      S_AVG_WAIT: begin
        cmd.div_op = DIV_AVG;
        cmd.avg_ld = ~stat.div_busy;
      end
      S_MUL: cmd.mul_ld = 1'b1;
      S_PIT_GO: begin
        cmd.div_op    = DIV_PIT;
        cmd.div_start = 1'b1;
      end
      S_PIT_WAIT: begin
        cmd.div_op   = DIV_PIT;
        cmd.pitch_ld = ~stat.div_busy;
      end
      S_PER_GO: begin
        cmd.div_op    = DIV_PER;
        cmd.div_start = 1'b1;
      end
      S_PER_WAIT: begin
        cmd.div_op    = DIV_PER;
        cmd.period_ld = ~stat.div_busy;
      end
      S_TICK: cmd.tick_upd = 1'b1;
      S_DONE: cmd.out_ld = stat.out_free;
      default: begin
        cmd.div_op = DIV_AVG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
